// ===== hdl/cwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwm_pkg
// Shared types, widths and the arctangent table for the clock-wipe key
// generator.
// ----------------------------------------------------------------------------
package cwm_pkg;

    localparam int MAX_DIMENSION = 4096;
    localparam int ANGLE_BITS    = 16;

    localparam int COORD_W   = $clog2(MAX_DIMENSION);
    localparam int FRAME_W   = COORD_W + 1;
    // doubled offset from centre, signed
    localparam int OFFS_W    = COORD_W + 3;
    localparam int GUARD_W   = 30;
    // offset, guard bits and room for the CORDIC gain
    localparam int VEC_W     = OFFS_W + GUARD_W + 3;
    localparam int TURN_W    = 32;
    localparam int TABLE_LEN = 26;
    localparam int STEPS     = (ANGLE_BITS + 2 < TABLE_LEN) ? ANGLE_BITS + 2 : TABLE_LEN;
    localparam int STEP_W    = $clog2(TABLE_LEN);
    localparam int SECTOR_W  = 5;
    localparam int KEY_W     = 8;
    localparam int CFG_W     = FRAME_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOFT_EDGES   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_TURN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTORS      = 3'd4;

    localparam logic [FRAME_W-1:0]  RST_FRAME_WIDTH  = FRAME_W'(1024);
    localparam logic [FRAME_W-1:0]  RST_FRAME_HEIGHT = FRAME_W'(768);
    localparam logic [SECTOR_W-1:0] RST_SECTORS      = '0;

    localparam logic [TURN_W-1:0] HALF_TURN = 32'h8000_0000;

    localparam int SOFT_SCALE  = 240;
    localparam int SOFT_OFFSET = 8;

    // vector state handed from cell to cell
    typedef struct packed {
        logic                     zero;
        logic signed [VEC_W-1:0]  u;
        logic signed [VEC_W-1:0]  v;
        logic [TURN_W-1:0]        z;
    } cwm_vec_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [TURN_W-1:0] atan_turn(input logic [STEP_W-1:0] idx);
        logic [TURN_W-1:0] a;
        begin
            unique case (idx)
                5'd0:    a = 32'h2000_0000;
                5'd1:    a = 32'h12E4_051E;
                5'd2:    a = 32'h09FB_385B;
                5'd3:    a = 32'h0511_11D4;
                5'd4:    a = 32'h028B_0D43;
                5'd5:    a = 32'h0145_D7E1;
                5'd6:    a = 32'h00A2_F61E;
                5'd7:    a = 32'h0051_7C55;
                5'd8:    a = 32'h0028_BE53;
                5'd9:    a = 32'h0014_5F2F;
                5'd10:   a = 32'h000A_2F98;
                5'd11:   a = 32'h0005_17CC;
                5'd12:   a = 32'h0002_8BE6;
                5'd13:   a = 32'h0001_45F3;
                5'd14:   a = 32'h0000_A2F9;
                5'd15:   a = 32'h0000_517C;
                5'd16:   a = 32'h0000_28BE;
                5'd17:   a = 32'h0000_145F;
                5'd18:   a = 32'h0000_0A2F;
                5'd19:   a = 32'h0000_0517;
                5'd20:   a = 32'h0000_028B;
                5'd21:   a = 32'h0000_0145;
                5'd22:   a = 32'h0000_00A2;
                5'd23:   a = 32'h0000_0051;
                5'd24:   a = 32'h0000_0028;
                5'd25:   a = 32'h0000_0014;
                default: a = '0;
            endcase
            return a;
        end
    endfunction

endpackage

// ===== hdl/cwm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwm_front
// Centre offset and half-plane fold; loads the first CORDIC vector.
// ----------------------------------------------------------------------------
module cwm_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cwm_pkg::COORD_W-1:0]   pixel_x,
    input  logic [cwm_pkg::COORD_W-1:0]   pixel_y,
    input  logic [cwm_pkg::FRAME_W-1:0]   frame_width,
    input  logic [cwm_pkg::FRAME_W-1:0]   frame_height,
    output logic                          out_valid,
    output cwm_pkg::cwm_vec_t             out_data,
    input  logic                          out_ready
);

    localparam int PAD_C = cwm_pkg::OFFS_W - cwm_pkg::COORD_W - 1;
    localparam int PAD_F = cwm_pkg::OFFS_W - cwm_pkg::FRAME_W;
    localparam int PAD_V = cwm_pkg::VEC_W - cwm_pkg::OFFS_W - cwm_pkg::GUARD_W;

    logic                               valid_reg;
    logic                               valid_next;
    cwm_pkg::cwm_vec_t                  data_reg;
    cwm_pkg::cwm_vec_t                  data_next;
    logic signed [cwm_pkg::OFFS_W-1:0]  dx;
    logic signed [cwm_pkg::OFFS_W-1:0]  dy;
    logic signed [cwm_pkg::OFFS_W-1:0]  xf;
    logic signed [cwm_pkg::OFFS_W-1:0]  yf;
    logic signed [cwm_pkg::OFFS_W-1:0]  yu;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        dx = $signed({{PAD_C{1'b0}}, pixel_x, 1'b0})
           - $signed({{PAD_F{1'b0}}, frame_width});
        dy = $signed({{PAD_C{1'b0}}, pixel_y, 1'b0})
           - $signed({{PAD_F{1'b0}}, frame_height});
        // y axis points up: smaller row is positive
        yu = -dy;
        data_next.zero = (dx == '0) && (dy == '0);
        if (yu < 0)
        begin
            xf = -dx;
            yf = -yu;
            data_next.z = cwm_pkg::HALF_TURN;
        end
        else
        begin
            xf = dx;
            yf = yu;
            data_next.z = '0;
        end
        data_next.u = $signed({{PAD_V{yf[cwm_pkg::OFFS_W-1]}}, yf, {cwm_pkg::GUARD_W{1'b0}}});
        data_next.v = $signed({{PAD_V{xf[cwm_pkg::OFFS_W-1]}}, xf, {cwm_pkg::GUARD_W{1'b0}}});
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hdl/cwm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwm_cell
// One CORDIC vectoring step: rotate towards the up axis and accumulate angle.
// ----------------------------------------------------------------------------
module cwm_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [cwm_pkg::STEP_W-1:0]    step,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  cwm_pkg::cwm_vec_t             in_data,
    output logic                          out_valid,
    output cwm_pkg::cwm_vec_t             out_data,
    input  logic                          out_ready
);

    logic                               valid_reg;
    logic                               valid_next;
    cwm_pkg::cwm_vec_t                  data_reg;
    cwm_pkg::cwm_vec_t                  data_next;
    logic signed [cwm_pkg::VEC_W-1:0]   su;
    logic signed [cwm_pkg::VEC_W-1:0]   sv;
    logic [cwm_pkg::TURN_W-1:0]         da;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        // step is tied off per cell, so the shifts reduce to wiring
        su = in_data.u >>> step;
        sv = in_data.v >>> step;
        da = cwm_pkg::atan_turn(step);
        data_next.zero = in_data.zero;
        if (in_data.v > 0)
        begin
            data_next.u = in_data.u + sv;
            data_next.v = in_data.v - su;
            data_next.z = in_data.z + da;
        end
        else
        begin
            data_next.u = in_data.u - sv;
            data_next.v = in_data.v + su;
            data_next.z = in_data.z - da;
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hdl/cwm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwm_back
// Angle rounding, sector scaling, half-turn offset and key level mapping.
// ----------------------------------------------------------------------------
module cwm_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  cwm_pkg::cwm_vec_t             in_data,
    input  logic                          soft_edges,
    input  logic                          half_turn_offset,
    input  logic [cwm_pkg::SECTOR_W-1:0]  sector_count,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cwm_pkg::KEY_W-1:0]     key_value
);

    localparam int AB    = cwm_pkg::ANGLE_BITS;
    localparam int DROP  = cwm_pkg::TURN_W - AB;
    localparam int PROD1 = AB + cwm_pkg::SECTOR_W;
    localparam int PROD2 = AB + cwm_pkg::KEY_W;

    localparam logic [cwm_pkg::TURN_W-1:0] ROUND_HALF = cwm_pkg::TURN_W'(1) << (DROP - 1);
    localparam logic [AB-1:0]              FRAC_HALF  = AB'(1) << (AB - 1);
    localparam logic [cwm_pkg::KEY_W-1:0]  SCALE      = cwm_pkg::KEY_W'(cwm_pkg::SOFT_SCALE);
    localparam logic [cwm_pkg::KEY_W-1:0]  OFFSET     = cwm_pkg::KEY_W'(cwm_pkg::SOFT_OFFSET);

    logic                          frac_valid_reg;
    logic                          frac_valid_next;
    logic [AB-1:0]                 frac_reg;
    logic [AB-1:0]                 frac_next;
    logic                          key_valid_reg;
    logic                          key_valid_next;
    logic [cwm_pkg::KEY_W-1:0]     key_reg;
    logic [cwm_pkg::KEY_W-1:0]     key_next;
    logic                          frac_ready;
    logic [cwm_pkg::TURN_W-1:0]    z_round;
    logic [AB-1:0]                 angle;
    logic [cwm_pkg::SECTOR_W-1:0]  sectors;
    logic [PROD1-1:0]              prod1;
    logic [AB-1:0]                 scaled;
    logic [PROD2-1:0]              prod2;

    assign frac_ready = !key_valid_reg || out_ready;
    assign in_ready   = !frac_valid_reg || frac_ready;

    // stage 1: round to ANGLE_BITS, times sectors, optional half turn
    always_comb
    begin
        z_round = in_data.z + ROUND_HALF;
        angle   = in_data.zero ? '0 : z_round[cwm_pkg::TURN_W-1:DROP];
        sectors = (sector_count == '0) ? cwm_pkg::SECTOR_W'(1) : sector_count;
        prod1   = PROD1'(angle) * PROD1'(sectors);
        scaled  = prod1[AB-1:0];
        frac_next = half_turn_offset ? scaled + FRAC_HALF : scaled;
        frac_valid_next = in_ready ? in_valid : frac_valid_reg;
    end

    // stage 2: key level
    always_comb
    begin
        prod2 = PROD2'(frac_reg) * PROD2'(SCALE);
        if (soft_edges)
        begin
            key_next = prod2[PROD2-1:AB] + OFFSET;
        end
        else
        begin
            key_next = frac_reg[AB-1:AB-cwm_pkg::KEY_W];
        end
        key_valid_next = frac_ready ? frac_valid_reg : key_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_valid_reg <= 1'b0;
            key_valid_reg  <= 1'b0;
        end
        else
        begin
            frac_valid_reg <= frac_valid_next;
            key_valid_reg  <= key_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            frac_reg <= frac_next;
        end
        if (frac_ready && frac_valid_reg)
        begin
            key_reg <= key_next;
        end
    end

    assign out_valid = key_valid_reg;
    assign key_value = key_reg;

endmodule

// ===== hdl/clock_wipe_mask_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_wipe_mask_generator
// Clock-wipe key level per pixel from its angle around the frame centre.
//
//   channel   signals                          transaction when
//   input     in_valid, in_stall, pixel_x/y    in_valid && !in_stall
//   output    out_valid, out_stall, key_value  out_valid && !out_stall
//   config    cfg_wr_en, cfg_index, cfg_data   cfg_wr_en
//
// One pixel per cycle sustained while out_stall is low. Stages: one offset
// stage, one CORDIC cell per step, two scaling stages. Every stage holds its
// own valid bit, so bubbles close up under a stall; in_stall rises only when
// every stage is full and out_stall is high. Reset clears the valid bits and
// loads the register defaults.
// ----------------------------------------------------------------------------
module clock_wipe_mask_generator
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [cwm_pkg::COORD_W-1:0]    pixel_x,
    input  logic [cwm_pkg::COORD_W-1:0]    pixel_y,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [cwm_pkg::KEY_W-1:0]      key_value,
    input  logic                           cfg_wr_en,
    input  logic [cwm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cwm_pkg::CFG_W-1:0]      cfg_data
);

    logic [cwm_pkg::FRAME_W-1:0]   frame_width_reg;
    logic [cwm_pkg::FRAME_W-1:0]   frame_height_reg;
    logic                          soft_edges_reg;
    logic                          half_turn_reg;
    logic [cwm_pkg::SECTOR_W-1:0]  sectors_reg;

    logic                          front_ready;
    logic                          chain_valid [0:cwm_pkg::STEPS];
    logic                          chain_ready [0:cwm_pkg::STEPS];
    cwm_pkg::cwm_vec_t             chain_data  [0:cwm_pkg::STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= cwm_pkg::RST_FRAME_WIDTH;
            frame_height_reg <= cwm_pkg::RST_FRAME_HEIGHT;
            soft_edges_reg   <= 1'b0;
            half_turn_reg    <= 1'b0;
            sectors_reg      <= cwm_pkg::RST_SECTORS;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                cwm_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[cwm_pkg::FRAME_W-1:0];
                cwm_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[cwm_pkg::FRAME_W-1:0];
                cwm_pkg::CFG_SOFT_EDGES:   soft_edges_reg   <= cfg_data[0];
                cwm_pkg::CFG_HALF_TURN:    half_turn_reg    <= cfg_data[0];
                cwm_pkg::CFG_SECTORS:      sectors_reg      <= cfg_data[cwm_pkg::SECTOR_W-1:0];
                default:                   ;
            endcase
        end
    end

    assign in_stall = !front_ready;

    cwm_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (front_ready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .out_valid    (chain_valid[0]),
        .out_data     (chain_data[0]),
        .out_ready    (chain_ready[0])
    );

    for (genvar k = 0; k < cwm_pkg::STEPS; k++)
    begin : g_cell
        cwm_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (cwm_pkg::STEP_W'(k)),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_data   (chain_data[k]),
            .out_valid (chain_valid[k+1]),
            .out_data  (chain_data[k+1]),
            .out_ready (chain_ready[k+1])
        );
    end

    cwm_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (chain_valid[cwm_pkg::STEPS]),
        .in_ready         (chain_ready[cwm_pkg::STEPS]),
        .in_data          (chain_data[cwm_pkg::STEPS]),
        .soft_edges       (soft_edges_reg),
        .half_turn_offset (half_turn_reg),
        .sector_count     (sectors_reg),
        .out_valid        (out_valid),
        .out_ready        (!out_stall),
        .key_value        (key_value)
    );

endmodule

// ===== test/clock_wipe_key_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_wipe_key_checker
// Watches the pixel, key and register ports of the clock-wipe key generator.
// It keeps its own copy of the registers, works out each pixel's key with an
// independent CORDIC angle calculation, and compares it with the keys that
// come out, in order.
// ----------------------------------------------------------------------------
module clock_wipe_key_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [cwm_pkg::COORD_W-1:0]    pixel_x,
    input  logic [cwm_pkg::COORD_W-1:0]    pixel_y,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [cwm_pkg::KEY_W-1:0]      key_value,
    input  logic                           cfg_wr_en,
    input  logic [cwm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cwm_pkg::CFG_W-1:0]      cfg_data,
    output int                             key_errors,
    output int                             keys_checked,
    output int                             keys_pending
);

    localparam int SPUN_W   = cwm_pkg::ANGLE_BITS + cwm_pkg::SECTOR_W;
    localparam int SCALED_W = cwm_pkg::ANGLE_BITS + cwm_pkg::KEY_W;

    logic [cwm_pkg::FRAME_W-1:0]  width_q;
    logic [cwm_pkg::FRAME_W-1:0]  height_q;
    logic                         soft_q;
    logic                         half_q;
    logic [cwm_pkg::SECTOR_W-1:0] sectors_q;

    logic [cwm_pkg::KEY_W-1:0]    key_queue[$];
    logic [cwm_pkg::KEY_W-1:0]    want;
    int                           pixels_taken;

    assign keys_pending = pixels_taken - keys_checked;

    // atan(2^-i) in 2^-32 turn units
    function automatic logic [cwm_pkg::TURN_W-1:0] step_turn(int i);
        case (i)
            0:       return 32'h2000_0000;
            1:       return 32'h12E4_051E;
            2:       return 32'h09FB_385B;
            3:       return 32'h0511_11D4;
            4:       return 32'h028B_0D43;
            5:       return 32'h0145_D7E1;
            6:       return 32'h00A2_F61E;
            7:       return 32'h0051_7C55;
            8:       return 32'h0028_BE53;
            9:       return 32'h0014_5F2F;
            10:      return 32'h000A_2F98;
            11:      return 32'h0005_17CC;
            12:      return 32'h0002_8BE6;
            13:      return 32'h0001_45F3;
            14:      return 32'h0000_A2F9;
            15:      return 32'h0000_517C;
            16:      return 32'h0000_28BE;
            17:      return 32'h0000_145F;
            18:      return 32'h0000_0A2F;
            19:      return 32'h0000_0517;
            20:      return 32'h0000_028B;
            21:      return 32'h0000_0145;
            22:      return 32'h0000_00A2;
            23:      return 32'h0000_0051;
            24:      return 32'h0000_0028;
            25:      return 32'h0000_0014;
            default: return '0;
        endcase
    endfunction

    // clockwise angle from up of (x right, y up), as a turn fraction
    function automatic logic [cwm_pkg::ANGLE_BITS-1:0] clockwise_turn(longint x, longint y);
        longint                     u;
        longint                     v;
        longint                     su;
        longint                     sv;
        logic [cwm_pkg::TURN_W-1:0] z;
        if (x == 0 && y == 0)
            return '0;
        z = '0;
        // lower half plane: rotate by half a turn first
        if (y < 0)
        begin
            x = -x;
            y = -y;
            z = cwm_pkg::HALF_TURN;
        end
        u = y <<< cwm_pkg::GUARD_W;
        v = x <<< cwm_pkg::GUARD_W;
        for (int i = 0; i < cwm_pkg::STEPS; i++)
        begin
            su = u >>> i;
            sv = v >>> i;
            if (v > 0)
            begin
                u = u + sv;
                v = v - su;
                z = z + step_turn(i);
            end
            else
            begin
                u = u - sv;
                v = v + su;
                z = z - step_turn(i);
            end
        end
        z = z + (cwm_pkg::TURN_W'(1) << (cwm_pkg::TURN_W - 1 - cwm_pkg::ANGLE_BITS));
        return z[cwm_pkg::TURN_W-1 -: cwm_pkg::ANGLE_BITS];
    endfunction

    function automatic logic [cwm_pkg::KEY_W-1:0] wipe_key(logic [cwm_pkg::COORD_W-1:0] px,
                                                           logic [cwm_pkg::COORD_W-1:0] py);
        longint                           dx;
        longint                           dy;
        logic [cwm_pkg::ANGLE_BITS-1:0]   angle;
        logic [cwm_pkg::ANGLE_BITS-1:0]   frac;
        logic [cwm_pkg::SECTOR_W-1:0]     n;
        logic [SPUN_W-1:0]                spun;
        logic [SCALED_W-1:0]              scaled;
        dx = 2 * longint'(px) - longint'(width_q);
        dy = 2 * longint'(py) - longint'(height_q);
        angle = clockwise_turn(dx, -dy);
        n = (sectors_q == '0) ? cwm_pkg::SECTOR_W'(1) : sectors_q;
        spun = SPUN_W'(angle) * SPUN_W'(n);
        frac = spun[cwm_pkg::ANGLE_BITS-1:0];
        if (half_q)
            frac = frac + (cwm_pkg::ANGLE_BITS'(1) << (cwm_pkg::ANGLE_BITS - 1));
        if (soft_q)
        begin
            scaled = SCALED_W'(frac) * SCALED_W'(cwm_pkg::SOFT_SCALE);
            return cwm_pkg::KEY_W'(cwm_pkg::SOFT_OFFSET)
                   + scaled[cwm_pkg::ANGLE_BITS +: cwm_pkg::KEY_W];
        end
        return frac[cwm_pkg::ANGLE_BITS-1 -: cwm_pkg::KEY_W];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_q      <= cwm_pkg::RST_FRAME_WIDTH;
            height_q     <= cwm_pkg::RST_FRAME_HEIGHT;
            soft_q       <= 1'b0;
            half_q       <= 1'b0;
            sectors_q    <= cwm_pkg::RST_SECTORS;
            key_queue.delete();
            key_errors   <= 0;
            keys_checked <= 0;
            pixels_taken <= 0;
        end
        else
        begin
            // keys first: a pixel taken this edge cannot be due yet
            if (out_valid && !out_stall)
            begin
                if (key_queue.size() == 0)
                begin
                    $error("key_value: no key expected, got %0d", key_value);
                    key_errors <= key_errors + 1;
                end
                else
                begin
                    want = key_queue.pop_front();
                    keys_checked <= keys_checked + 1;
                    if (key_value !== want)
                    begin
                        $error("key_value mismatch: expected %0d, got %0d", want, key_value);
                        key_errors <= key_errors + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                key_queue.push_back(wipe_key(pixel_x, pixel_y));
                pixels_taken <= pixels_taken + 1;
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    cwm_pkg::CFG_FRAME_WIDTH:  width_q   <= cfg_data[cwm_pkg::FRAME_W-1:0];
                    cwm_pkg::CFG_FRAME_HEIGHT: height_q  <= cfg_data[cwm_pkg::FRAME_W-1:0];
                    cwm_pkg::CFG_SOFT_EDGES:   soft_q    <= cfg_data[0];
                    cwm_pkg::CFG_HALF_TURN:    half_q    <= cfg_data[0];
                    cwm_pkg::CFG_SECTORS:      sectors_q <= cfg_data[cwm_pkg::SECTOR_W-1:0];
                    default:                   ;
                endcase
            end
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the clock-wipe key generator: directed pixels on the axes,
// corners and centre, then random pixels under a range of frame sizes,
// sector counts and edge modes, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;

    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = cwm_pkg::STEPS + 3 + 8;
    localparam int BLOCK_PIXELS = 50;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [cwm_pkg::COORD_W-1:0]   pixel_x;
    logic [cwm_pkg::COORD_W-1:0]   pixel_y;
    logic                          out_valid;
    logic                          out_stall;
    logic [cwm_pkg::KEY_W-1:0]     key_value;
    logic                          cfg_wr_en;
    logic [cwm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [cwm_pkg::CFG_W-1:0]     cfg_data;

    int key_errors;
    int keys_checked;
    int keys_pending;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int width_now   = 1024;
    int height_now  = 768;
    int pixels_sent = 0;
    int settings_used = 0;
    int quiet_cycles = 0;

    clock_wipe_mask_generator uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .key_value (key_value),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    clock_wipe_key_checker key_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .key_value    (key_value),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .key_errors   (key_errors),
        .keys_checked (keys_checked),
        .keys_pending (keys_pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < rx_idle_pct);

    // watchdog: cycles with no transaction on any port
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timed out with %0d keys outstanding", keys_pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_pixel(int x, int y);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_x  <= cwm_pkg::COORD_W'(x);
        pixel_y  <= cwm_pkg::COORD_W'(y);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pixels_sent++;
    endtask

    // stop sending and wait for every key in flight
    task automatic drain_keys();
        in_valid <= 1'b0;
        @(posedge clk);
        while (keys_pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [cwm_pkg::CFG_IDX_W-1:0] idx,
                             logic [cwm_pkg::CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // upper data bits on the one-bit and sector registers are random noise
    task automatic apply_settings(int fw, int fh, int soft_on, int half, int sectors);
        drain_keys();
        write_reg(cwm_pkg::CFG_FRAME_WIDTH, cwm_pkg::CFG_W'(fw));
        write_reg(cwm_pkg::CFG_FRAME_HEIGHT, cwm_pkg::CFG_W'(fh));
        write_reg(cwm_pkg::CFG_SOFT_EDGES,
                  (cwm_pkg::CFG_W'($urandom) << 1) | cwm_pkg::CFG_W'(soft_on & 1));
        write_reg(cwm_pkg::CFG_HALF_TURN,
                  (cwm_pkg::CFG_W'($urandom) << 1) | cwm_pkg::CFG_W'(half & 1));
        write_reg(cwm_pkg::CFG_SECTORS,
                  (cwm_pkg::CFG_W'($urandom) << cwm_pkg::SECTOR_W)
                  | cwm_pkg::CFG_W'(sectors & ((1 << cwm_pkg::SECTOR_W) - 1)));
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        width_now  = fw;
        height_now = fh;
        settings_used++;
    endtask

    // mode 0: anywhere, mode 1: within a few pixels of centre, else inside frame
    function automatic int place(int mode, int span);
        int lim;
        int c;
        if (mode == 0)
            return $urandom_range(4095);
        lim = (span < 1) ? 0 : ((span > 4096) ? 4095 : span - 1);
        if (mode == 1)
        begin
            c = span / 2 + int'($urandom_range(6)) - 3;
            return (c < 0) ? 0 : ((c > 4095) ? 4095 : c);
        end
        return $urandom_range(lim);
    endfunction

    task automatic send_random_pixel();
        int mode;
        mode = $urandom_range(7);
        send_pixel(place(mode, width_now), place(mode, height_now));
    endtask

    task automatic pick_settings(int pick);
        case (pick)
            0: apply_settings(1, 1, 0, 0, 0);
            1: apply_settings(4096, 4096, 1, 1, 16);
            2: apply_settings(8191, 0, 1, 0, 31);
            default:
                apply_settings($urandom_range(1, 4096), $urandom_range(1, 4096),
                               $urandom_range(1), $urandom_range(1),
                               ($urandom_range(7) == 0) ? $urandom_range(17, 31)
                                                        : $urandom_range(16));
        endcase
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        pixel_x   <= '0;
        pixel_y   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: centre, the four axes, corners, alternating bits
        send_pixel(512, 384);
        send_pixel(512, 0);
        send_pixel(1023, 384);
        send_pixel(512, 767);
        send_pixel(0, 384);
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        send_pixel(4095, 0);
        send_pixel(0, 4095);
        send_pixel(2730, 1365);
        send_pixel(1365, 2730);

        // writes to unused register slots must change nothing
        drain_keys();
        for (int r = cwm_pkg::CFG_SECTORS + 1; r < (1 << cwm_pkg::CFG_IDX_W); r++)
            write_reg(cwm_pkg::CFG_IDX_W'(r), '1);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        send_pixel(0, 0);
        send_pixel(4095, 0);

        apply_settings(4096, 4096, 1, 1, 16);
        send_pixel(2048, 2048);
        send_pixel(4095, 2048);
        send_pixel(0, 0);
        send_pixel(2048, 0);

        // oversized width, zero height, sector count past sixteen
        apply_settings(8191, 0, 0, 1, 31);
        send_pixel(4095, 0);
        send_pixel(0, 4095);
        send_pixel(2048, 4095);

        apply_settings(1, 1, 0, 0, 1);
        send_pixel(0, 0);
        send_pixel(1, 1);
        send_pixel(0, 1);

        // zero frame puts the centre exactly on pixel (0,0)
        apply_settings(0, 0, 1, 0, 0);
        send_pixel(0, 0);
        send_pixel(4095, 4095);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       begin tx_idle_pct = 21; rx_idle_pct = 77; end
                1:       begin tx_idle_pct = 77; rx_idle_pct = 21; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            for (int blk = 0; blk < 3; blk++)
            begin
                pick_settings(phase * 3 + blk);
                for (int k = 0; k < BLOCK_PIXELS; k++)
                begin
                    if (phase == 0 && blk == 1 && k == BLOCK_PIXELS / 2)
                        drain_keys();
                    send_random_pixel();
                end
            end
        end

        drain_keys();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d pixels under %0d register settings; %0d keys compared.",
                 pixels_sent, settings_used, keys_checked);
        $display("Covered frame extremes, sector counts 0..31, both edge modes, offset on/off.");
        if (key_errors == 0 && keys_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== clock_wipe_mask_generator.f =====
hdl/cwm_pkg.sv
hdl/cwm_front.sv
hdl/cwm_cell.sv
hdl/cwm_back.sv
hdl/clock_wipe_mask_generator.sv
test/clock_wipe_key_checker.sv
test/tb.sv
